@@ rtl/core/cykr_pkg.sv @@
// Shared types, constants and the pair-reduction function for the CYK reducer.
`timescale 1ns / 1ps
package cykr_pkg;

	localparam int CYKR_MAX_LEN = 64;
	localparam int NUM_SYMS     = 4;
	localparam int SYM_W        = 2;
	localparam int RULE_W       = NUM_SYMS * NUM_SYMS;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RULES_TO_B = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RULES_TO_R = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RULES_TO_Y = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RULES_TO_W = 2'd3;

	typedef logic [NUM_SYMS-1:0]              sym_set_t;
	typedef logic [NUM_SYMS-1:0][RULE_W-1:0]  rule_bank_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ISSUE,
		ST_DRAIN,
		ST_RESULT
	} ctrl_state_t;

	typedef struct packed {
		logic     done;
		sym_set_t reachable;
		logic     overflow;
	} cykr_result_t;

	// Every product reachable from any left/right symbol pair of the two sets.
	function automatic sym_set_t cykr_combine(sym_set_t left, sym_set_t right,
			rule_bank_t rules);
		sym_set_t res;
		res = '0;
		for (int a = 0; a < NUM_SYMS; a++) begin
			for (int b = 0; b < NUM_SYMS; b++) begin
				for (int p = 0; p < NUM_SYMS; p++) begin
					if (left[a] && right[b] && rules[p][a*NUM_SYMS + b])
						res[p] = 1'b1;
				end
			end
		end
		return res;
	endfunction

endpackage

@@ rtl/core/cykr_table_mem.sv @@
// Interval-set table: one write port, two registered read ports.
`timescale 1ns / 1ps
module cykr_table_mem import cykr_pkg::*; #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  sym_set_t      wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output sym_set_t      rdata_a,
	output sym_set_t      rdata_b
);

	sym_set_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ rtl/core/cykr_ctrl.sv @@
// Symbol loader and interval-fill sequencer driving the table memory.
`timescale 1ns / 1ps
module cykr_ctrl import cykr_pkg::*; #(
	parameter int MAX_LEN = CYKR_MAX_LEN,
	parameter int IW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [SYM_W-1:0] symbol,
	input  logic            is_last,
	input  rule_bank_t      rules,
	input  logic            out_free,
	output cykr_result_t    res,
	output logic            mem_we,
	output logic [2*IW-1:0] mem_waddr,
	output sym_set_t        mem_wdata,
	output logic [2*IW-1:0] mem_raddr_a,
	output logic [2*IW-1:0] mem_raddr_b,
	input  sym_set_t        mem_rdata_a,
	input  sym_set_t        mem_rdata_b
);

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int EW = CW + 1;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

	ctrl_state_t   state_q, state_d;
	logic [CW-1:0] cnt_q, len_q;
	logic          ovf_q;
	logic [IW-1:0] l_q, k_q;
	logic          rvalid_s1;
	sym_set_t      acc_q;
	sym_set_t      res_reach_q;
	logic          res_ovf_q;

	logic          accept;
	logic          room;
	logic          ovf_now;
	logic [EW-1:0] r_full;
	logic [EW-1:0] end_full;
	logic [IW-1:0] r_idx;
	logic [IW-1:0] k_next;
	logic          last_split;
	logic          last_of_len;
	logic          fill_done;
	sym_set_t      acc_next;

	assign accept      = in_valid && in_ready;
	assign room        = (cnt_q < MAX_CNT);
	assign ovf_now     = ovf_q || !room;
	assign end_full    = EW'(l_q) + EW'(len_q);
	assign r_full      = end_full - EW'(1);
	assign r_idx       = r_full[IW-1:0];
	assign k_next      = k_q + IW'(1);
	assign last_split  = (k_next == r_idx);
	assign last_of_len = (end_full == EW'(cnt_q));
	assign fill_done   = last_of_len && (len_q == cnt_q);
	assign acc_next    = rvalid_s1 ? (acc_q | cykr_combine(mem_rdata_a, mem_rdata_b, rules))
	                               : acc_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && is_last)
					state_d = (ovf_now || cnt_q == '0) ? ST_RESULT : ST_ISSUE;
			end
			ST_ISSUE: begin
				if (last_split)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = fill_done ? ST_RESULT : ST_ISSUE;
			end
			ST_RESULT: begin
				if (out_free)
					state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = {l_q, r_idx};
		mem_wdata   = acc_next;
		mem_raddr_a = {l_q, k_q};
		mem_raddr_b = {k_next, r_idx};
		res         = '{done: 1'b0, reachable: res_reach_q, overflow: res_ovf_q};
		unique case (state_q)
			ST_LOAD: begin
				in_ready  = 1'b1;
				mem_we    = accept && room;
				mem_waddr = {cnt_q[IW-1:0], cnt_q[IW-1:0]};
				mem_wdata = sym_set_t'(1) << symbol;
			end
			ST_ISSUE: ;
			ST_DRAIN: mem_we = 1'b1;
			ST_RESULT: res.done = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			rvalid_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= (state_q == ST_ISSUE);
			if (state_q == ST_LOAD && accept) begin
				if (is_last && (ovf_now || cnt_q == '0)) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end else if (room) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == ST_DRAIN && fill_done)
				cnt_q <= '0;
		end
	end

	// Datapath counters and accumulator; sequenced by the state register.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				if (accept && is_last) begin
					len_q       <= CW'(2);
					l_q         <= '0;
					k_q         <= '0;
					acc_q       <= '0;
					res_ovf_q   <= ovf_now;
					res_reach_q <= ovf_now ? sym_set_t'(0) : (sym_set_t'(1) << symbol);
				end
			end
			ST_ISSUE: begin
				acc_q <= acc_next;
				if (!last_split)
					k_q <= k_next;
			end
			ST_DRAIN: begin
				acc_q <= '0;
				if (fill_done) begin
					res_reach_q <= acc_next;
					res_ovf_q   <= 1'b0;
				end else if (last_of_len) begin
					len_q <= len_q + CW'(1);
					l_q   <= '0;
					k_q   <= '0;
				end else begin
					l_q <= l_q + IW'(1);
					k_q <= l_q + IW'(1);
				end
			end
			ST_RESULT: ;
			default: ;
		endcase
	end

endmodule

@@ rtl/core/cyk_four_symbol_reduction.sv @@
// Top level: rule registers, result register, loader/sequencer and table memory.
//
//  port group                  | dir | handshake          | payload
//  ----------------------------+-----+--------------------+-------------------------
//  symbol input                | in  | in_valid/in_ready  | symbol[1:0], is_last
//  result output               | out | out_valid/out_ready| reachable[3:0], overflow
//  rule registers              | in  | cfg_we             | cfg_index[1:0], cfg_data[15:0]
//
// Each symbol that fits within MAX_LEN is written to the diagonal of the table memory.
// After the last symbol of a string of two or more symbols that did not overflow, the fill
// walks every interval and split: ST_ISSUE reads and combines each split of an interval
// and ST_DRAIN then writes the interval's set to the table memory.
// Reset clears control state and the rule registers; the table needs no clearing.
// No symbol is taken during the fill; a held result stalls only the next fill's end.
`timescale 1ns / 1ps
module cyk_four_symbol_reduction import cykr_pkg::*; #(
	parameter int MAX_LEN = CYKR_MAX_LEN
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [SYM_W-1:0]     symbol,
	input  logic                 is_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [NUM_SYMS-1:0]  reachable,
	output logic                 overflow,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RULE_W-1:0]    cfg_data
);

	localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	rule_bank_t      rules_q;
	logic            out_valid_q;
	sym_set_t        reachable_q;
	logic            overflow_q;
	logic            out_free;
	cykr_result_t    res;
	logic            mem_we;
	logic [2*IW-1:0] mem_waddr;
	sym_set_t        mem_wdata;
	logic [2*IW-1:0] mem_raddr_a;
	logic [2*IW-1:0] mem_raddr_b;
	sym_set_t        mem_rdata_a;
	sym_set_t        mem_rdata_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rules_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RULES_TO_B: rules_q[0] <= cfg_data;
				REG_RULES_TO_R: rules_q[1] <= cfg_data;
				REG_RULES_TO_Y: rules_q[2] <= cfg_data;
				REG_RULES_TO_W: rules_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			reachable_q <= res.reachable;
			overflow_q  <= res.overflow;
		end
	end

	assign out_valid = out_valid_q;
	assign reachable = reachable_q;
	assign overflow  = overflow_q;

	cykr_ctrl #(
		.MAX_LEN (MAX_LEN),
		.IW      (IW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.symbol      (symbol),
		.is_last     (is_last),
		.rules       (rules_q),
		.out_free    (out_free),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr_a (mem_raddr_a),
		.mem_raddr_b (mem_raddr_b),
		.mem_rdata_a (mem_rdata_a),
		.mem_rdata_b (mem_rdata_b)
	);

	cykr_table_mem #(
		.AW (2 * IW)
	) u_table (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

endmodule
